>>> sv/pbr_pkg.sv
// Shared types and constants of the phase-bit ring pipe pointer engine.
// Used by the front, the back and the top level; depends on nothing else.
package pbr_pkg;

    localparam int PTR_W   = 16;
    localparam int OFFS_W  = 15;
    localparam int WORDS_W = 14;
    localparam int CIDX_W  = 2;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_XFER = 1'b1;

    localparam logic DIR_READ  = 1'b0;
    localparam logic DIR_WRITE = 1'b1;

    localparam logic [CIDX_W-1:0] REG_BASE = 2'd0;
    localparam logic [CIDX_W-1:0] REG_RING = 2'd1;
    localparam logic [CIDX_W-1:0] REG_DIR  = 2'd2;

    localparam logic [PTR_W-1:0] PHASE_MASK = 16'h8000;

    typedef struct packed {
        logic             xfer;
        logic [PTR_W-1:0] value;
    } item_t;

    typedef struct packed {
        logic [PTR_W-1:0]  base;
        logic [OFFS_W-1:0] ring_len;
        logic              dir;
    } cfg_t;

endpackage

>>> sv/pbr_front.sv
// Front of the pointer engine: accepts requests, classifies them and queues them.
// Holds a two-entry queue toward the back; depends on pbr_pkg.
module pbr_front
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     cmd,
    input  logic [pbr_pkg::PTR_W-1:0] partner_value,
    input  logic [pbr_pkg::PTR_W-1:0] request_bytes,
    output logic                     q_valid,
    output pbr_pkg::item_t           q_item,
    input  logic                     q_pop
);

    pbr_pkg::item_t slot_reg [2];
    pbr_pkg::item_t new_item;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic           push;

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];

    // A transfer keeps its length rounded down to even; a load keeps the pointer.
    always_comb
    begin
        new_item.xfer = (cmd == pbr_pkg::CMD_XFER);
        if (cmd == pbr_pkg::CMD_XFER)
        begin
            new_item.value = {request_bytes[pbr_pkg::PTR_W-1:1], 1'b0};
        end
        else
        begin
            new_item.value = partner_value;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (push && !q_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (q_pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= new_item;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");

    a_pop_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> count_reg != 2'd0)
        else $error("queue popped while empty");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd1) |-> (wr_ptr_reg != rd_ptr_reg))
        else $error("queue pointers disagree with count");

endmodule

>>> sv/pbr_back.sv
// Back of the pointer engine: serves queued requests one result per cycle while out_ready allows.
// Holds both pointers, the chunk sequencer and the output register; depends on pbr_pkg.
module pbr_back
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  pbr_pkg::cfg_t               cfg,
    input  logic                        q_valid,
    input  pbr_pkg::item_t              q_item,
    output logic                        q_pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        is_chunk,
    output logic [pbr_pkg::PTR_W-1:0]   chunk_addr,
    output logic [pbr_pkg::WORDS_W-1:0] chunk_words,
    output logic [pbr_pkg::OFFS_W-1:0]  available,
    output logic [pbr_pkg::PTR_W-1:0]   own_value,
    output logic [pbr_pkg::PTR_W-1:0]   unserved,
    output logic                        notify,
    output logic                        last
);

    typedef enum logic [2:0]
    {
        ST_START = 3'b001,
        ST_NEXT  = 3'b010,
        ST_END   = 3'b100
    } seq_state_t;

    seq_state_t                  state_reg;
    seq_state_t                  state_next;
    logic [pbr_pkg::PTR_W-1:0]   own_reg;
    logic [pbr_pkg::PTR_W-1:0]   partner_reg;
    logic [pbr_pkg::PTR_W-1:0]   len_reg;
    logic                        out_valid_reg;
    logic                        is_chunk_reg;
    logic [pbr_pkg::PTR_W-1:0]   chunk_addr_reg;
    logic [pbr_pkg::WORDS_W-1:0] chunk_words_reg;
    logic [pbr_pkg::PTR_W-1:0]   unserved_reg;
    logic                        notify_reg;
    logic                        last_reg;

    logic                        emit_ok;
    logic                        fire;
    logic [pbr_pkg::PTR_W-1:0]   len_cur;
    logic [pbr_pkg::PTR_W-1:0]   phase;
    logic                        same;
    logic [pbr_pkg::OFFS_W-1:0]  pos;
    logic [pbr_pkg::OFFS_W-1:0]  endp;
    logic                        blocked;
    logic [pbr_pkg::OFFS_W-1:0]  span;
    logic [pbr_pkg::OFFS_W-1:0]  cur_raw;
    logic [pbr_pkg::OFFS_W-1:0]  cur;
    logic [pbr_pkg::PTR_W-1:0]   sum;
    logic                        wrap;
    logic                        do_chunk;
    logic [pbr_pkg::PTR_W-1:0]   own_adv;
    logic [pbr_pkg::OFFS_W-1:0]  avail_add;

    assign emit_ok = !out_valid_reg || out_ready;
    assign fire    = q_valid && emit_ok;
    assign len_cur = (state_reg == ST_START) ? q_item.value : len_reg;

    assign phase = own_reg ^ partner_reg;
    assign same  = !phase[pbr_pkg::PTR_W-1];
    assign pos   = own_reg[pbr_pkg::OFFS_W-1:0];

    always_comb
    begin
        if (cfg.dir == pbr_pkg::DIR_READ)
        begin
            blocked = (phase == '0);
            endp    = same ? partner_reg[pbr_pkg::OFFS_W-1:0] : cfg.ring_len;
        end
        else
        begin
            blocked = (phase == pbr_pkg::PHASE_MASK);
            endp    = same ? cfg.ring_len : partner_reg[pbr_pkg::OFFS_W-1:0];
        end
    end

    assign span    = (endp > pos) ? (endp - pos) : '0;
    assign cur_raw = (len_cur < {1'b0, span}) ? len_cur[pbr_pkg::OFFS_W-1:0] : span;
    assign cur     = {cur_raw[pbr_pkg::OFFS_W-1:1], 1'b0};
    assign sum     = {1'b0, pos} + {1'b0, cur};
    assign wrap    = (sum >= {1'b0, cfg.ring_len});
    assign own_adv = wrap ? {~own_reg[pbr_pkg::PTR_W-1], {pbr_pkg::OFFS_W{1'b0}}}
                          : {own_reg[pbr_pkg::PTR_W-1], sum[pbr_pkg::OFFS_W-1:0]};

    assign do_chunk = q_item.xfer && (state_reg != ST_END) && (len_cur != '0)
                      && !blocked && (cur != '0);

    assign q_pop = fire && !do_chunk;

    always_comb
    begin
        state_next = state_reg;
        if (fire)
        begin
            if (do_chunk)
            begin
                case (state_reg)
                    ST_START: state_next = ST_NEXT;
                    ST_NEXT:  state_next = ST_END;
                    default:  state_next = ST_END;
                endcase
            end
            else
            begin
                state_next = ST_START;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_START;
            own_reg       <= '0;
            partner_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (fire)
            begin
                out_valid_reg <= 1'b1;
                if (!q_item.xfer)
                begin
                    partner_reg <= q_item.value;
                end
                else if (do_chunk)
                begin
                    own_reg <= own_adv;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            if (do_chunk)
            begin
                len_reg         <= len_cur - {1'b0, cur};
                is_chunk_reg    <= 1'b1;
                chunk_addr_reg  <= cfg.base + {2'b00, pos[pbr_pkg::OFFS_W-1:1]};
                chunk_words_reg <= cur[pbr_pkg::OFFS_W-1:1];
                unserved_reg    <= '0;
                notify_reg      <= 1'b0;
                last_reg        <= 1'b0;
            end
            else
            begin
                is_chunk_reg    <= 1'b0;
                chunk_addr_reg  <= '0;
                chunk_words_reg <= '0;
                unserved_reg    <= q_item.xfer ? len_cur : '0;
                notify_reg      <= q_item.xfer && (state_reg != ST_START);
                last_reg        <= 1'b1;
            end
        end
    end

    // The pointers only change when a result is loaded, so the waiting result
    // can read its pointer and fill level straight from them.
    always_comb
    begin
        if (cfg.dir == pbr_pkg::DIR_READ)
        begin
            avail_add = same ? '0 : cfg.ring_len;
        end
        else
        begin
            avail_add = same ? cfg.ring_len : '0;
        end
    end

    assign available = partner_reg[pbr_pkg::OFFS_W-1:0] - pos + avail_add;
    assign own_value   = own_reg;
    assign out_valid   = out_valid_reg;
    assign is_chunk    = is_chunk_reg;
    assign chunk_addr  = chunk_addr_reg;
    assign chunk_words = chunk_words_reg;
    assign unserved    = unserved_reg;
    assign notify      = notify_reg;
    assign last        = last_reg;

    a_chunk_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(is_chunk_reg && (last_reg || notify_reg)))
        else $error("chunk result marked as last or notify");

    a_chunk_words: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && is_chunk_reg) |-> (chunk_words_reg != '0))
        else $error("empty chunk emitted");

    a_pop_status: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (out_valid_reg && last_reg && (state_reg == ST_START)))
        else $error("item retired without a status result");

endmodule

>>> sv/phase_bit_ring_pipe_engine.sv
// Top level of the phase-bit ring pipe pointer engine: configuration registers
// and the front/back pair joined by a request queue; depends on pbr_pkg, pbr_front, pbr_back.
//
//   Channel  Handshake              Payload
//   in       in_valid / in_ready    cmd, partner_value, request_bytes
//   out      out_valid / out_ready  is_chunk, chunk_addr, chunk_words, available,
//                                   own_value, unserved, notify, last
//   cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// The back emits one result per cycle while out_ready allows: a load request
// yields one result, a transfer one to three (up to two chunks, then the status result).
// A two-entry queue sits between front and back, so requests keep arriving
// while the single output register waits on out_ready.
// Reset clears both pointers, the queue and the base; ring size resets to 2, dir to read.
module phase_bit_ring_pipe_engine
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        cmd,
    input  logic [pbr_pkg::PTR_W-1:0]   partner_value,
    input  logic [pbr_pkg::PTR_W-1:0]   request_bytes,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        is_chunk,
    output logic [pbr_pkg::PTR_W-1:0]   chunk_addr,
    output logic [pbr_pkg::WORDS_W-1:0] chunk_words,
    output logic [pbr_pkg::OFFS_W-1:0]  available,
    output logic [pbr_pkg::PTR_W-1:0]   own_value,
    output logic [pbr_pkg::PTR_W-1:0]   unserved,
    output logic                        notify,
    output logic                        last,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [pbr_pkg::CIDX_W-1:0]  cfg_index,
    input  logic [pbr_pkg::PTR_W-1:0]   cfg_data
);

    logic [pbr_pkg::PTR_W-1:0]  base_reg;
    logic [pbr_pkg::OFFS_W-1:0] ring_reg;
    logic                       dir_reg;
    logic [pbr_pkg::OFFS_W-1:0] ring_even;
    pbr_pkg::cfg_t              cfg;
    logic                       q_valid;
    pbr_pkg::item_t             q_item;
    logic                       q_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
            ring_reg <= 15'd2;
            dir_reg  <= pbr_pkg::DIR_READ;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                pbr_pkg::REG_BASE: base_reg <= cfg_data;
                pbr_pkg::REG_RING: ring_reg <= cfg_data[pbr_pkg::OFFS_W-1:0];
                pbr_pkg::REG_DIR:  dir_reg  <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // An odd size is rounded down; a size that rounds to zero counts as two bytes.
    assign ring_even    = {ring_reg[pbr_pkg::OFFS_W-1:1], 1'b0};
    assign cfg.base     = base_reg;
    assign cfg.ring_len = (ring_even == '0) ? 15'd2 : ring_even;
    assign cfg.dir      = dir_reg;

    pbr_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .cmd           (cmd),
        .partner_value (partner_value),
        .request_bytes (request_bytes),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop)
    );

    pbr_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .is_chunk    (is_chunk),
        .chunk_addr  (chunk_addr),
        .chunk_words (chunk_words),
        .available   (available),
        .own_value   (own_value),
        .unserved    (unserved),
        .notify      (notify),
        .last        (last)
    );

endmodule

>>> tb/sv/phase_bit_ring_pipe_engine_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of the phase-bit ring pipe pointer engine: directed
// and random requests against a built-in pointer predictor. Depends on pbr_pkg and phase_bit_ring_pipe_engine.
module phase_bit_ring_pipe_engine_test;

    localparam int PTR_W   = pbr_pkg::PTR_W;
    localparam int OFFS_W  = pbr_pkg::OFFS_W;
    localparam int WORDS_W = pbr_pkg::WORDS_W;
    localparam int CIDX_W  = pbr_pkg::CIDX_W;

    localparam int STALL_LIMIT = 4000;
    localparam logic [CIDX_W-1:0] REG_NONE = 2'd3;

    typedef struct {
        logic                is_chunk;
        logic [PTR_W-1:0]    chunk_addr;
        logic [WORDS_W-1:0]  chunk_words;
        logic [OFFS_W-1:0]   available;
        logic [PTR_W-1:0]    own_value;
        logic [PTR_W-1:0]    unserved;
        logic                notify;
        logic                last;
    } ring_result_t;

    class ring_scoreboard;
        logic [PTR_W-1:0]  base_addr;
        logic [OFFS_W-1:0] ring_reg;
        logic              dir_reg;
        logic [PTR_W-1:0]  own_ptr;
        logic [PTR_W-1:0]  partner_ptr;
        ring_result_t      expected_q[$];
        int                mismatches;
        int                results_seen;
        int                chunks_seen;

        function new();
            base_addr = '0;
            ring_reg = 15'd2;
            dir_reg = pbr_pkg::DIR_READ;
            own_ptr = '0;
            partner_ptr = '0;
            mismatches = 0;
            results_seen = 0;
            chunks_seen = 0;
        endfunction

        function int ring_size();
            int l;
            l = int'(ring_reg & 15'h7FFE);
            return (l != 0) ? l : 2;
        endfunction

        function logic [OFFS_W-1:0] avail_bytes();
            int v;
            bit same;
            same = ((own_ptr ^ partner_ptr) & pbr_pkg::PHASE_MASK) == '0;
            v = int'(partner_ptr) - int'(own_ptr);
            if (dir_reg == pbr_pkg::DIR_READ)
                v = v + (same ? 0 : ring_size());
            else
                v = v + (same ? ring_size() : 0);
            return v[OFFS_W-1:0];
        endfunction

        function void queue_result(logic chunk, logic [PTR_W-1:0] addr, int words,
                                   int left, logic moved, logic fin);
            ring_result_t r;
            r.is_chunk = chunk;
            r.chunk_addr = addr;
            r.chunk_words = words[WORDS_W-1:0];
            r.available = avail_bytes();
            r.own_value = own_ptr;
            r.unserved = left[PTR_W-1:0];
            r.notify = moved;
            r.last = fin;
            expected_q.push_back(r);
        endfunction

        function void write_reg(logic [CIDX_W-1:0] idx, logic [PTR_W-1:0] data);
            case (idx)
                pbr_pkg::REG_BASE: base_addr = data;
                pbr_pkg::REG_RING: ring_reg = data[OFFS_W-1:0];
                pbr_pkg::REG_DIR:  dir_reg = data[0];
                default: ;
            endcase
        endfunction

        function void note_request(logic c, logic [PTR_W-1:0] pv, logic [PTR_W-1:0] rb);
            int len;
            int l;
            int pos;
            int endp;
            int span;
            int cur;
            logic [PTR_W-1:0] phase;
            logic moved;
            if (c == pbr_pkg::CMD_LOAD)
            begin
                partner_ptr = pv;
                queue_result(1'b0, '0, 0, 0, 1'b0, 1'b1);
                return;
            end
            len = int'(rb & 16'hFFFE);
            l = ring_size();
            moved = 1'b0;
            for (int k = 0; k < 2 && len > 0; k++)
            begin
                phase = own_ptr ^ partner_ptr;
                pos = int'(own_ptr[OFFS_W-1:0]);
                if (dir_reg == pbr_pkg::DIR_READ)
                begin
                    if (phase == '0)
                        break;
                    endp = (phase < pbr_pkg::PHASE_MASK) ?
                           int'(partner_ptr[OFFS_W-1:0]) : l;
                end
                else
                begin
                    if (phase == pbr_pkg::PHASE_MASK)
                        break;
                    endp = (phase < pbr_pkg::PHASE_MASK) ?
                           l : int'(partner_ptr[OFFS_W-1:0]);
                end
                span = (endp > pos) ? endp - pos : 0;
                cur = (len < span) ? len : span;
                cur = cur & 32'hFFFE;
                if (cur == 0)
                    break;
                len = len - cur;
                if (pos + cur < l)
                    own_ptr = own_ptr + cur[PTR_W-1:0];
                else
                    own_ptr = ~own_ptr & pbr_pkg::PHASE_MASK;
                moved = 1'b1;
                queue_result(1'b1, base_addr + 16'(pos >> 1), cur >> 1, 0, 1'b0, 1'b0);
            end
            queue_result(1'b0, '0, 0, len, moved, 1'b1);
        endfunction

        function void check_result(ring_result_t got);
            ring_result_t exp;
            results_seen++;
            if (got.is_chunk === 1'b1)
                chunks_seen++;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result with nothing expected: chunk=%b addr=%h words=%h",
                             got.is_chunk, got.chunk_addr, got.chunk_words);
                return;
            end
            exp = expected_q.pop_front();
            if (got.is_chunk !== exp.is_chunk || got.chunk_addr !== exp.chunk_addr ||
                got.chunk_words !== exp.chunk_words || got.available !== exp.available ||
                got.own_value !== exp.own_value || got.unserved !== exp.unserved ||
                got.notify !== exp.notify || got.last !== exp.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("ERROR: expected chunk=%b addr=%h words=%h avail=%h own=%h",
                             exp.is_chunk, exp.chunk_addr, exp.chunk_words,
                             exp.available, exp.own_value);
                    $display("       unserved=%h notify=%b last=%b", exp.unserved,
                             exp.notify, exp.last);
                    $display("       actual   chunk=%b addr=%h words=%h avail=%h own=%h",
                             got.is_chunk, got.chunk_addr, got.chunk_words,
                             got.available, got.own_value);
                    $display("       unserved=%h notify=%b last=%b", got.unserved,
                             got.notify, got.last);
                end
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic                cmd;
    logic [PTR_W-1:0]    partner_value;
    logic [PTR_W-1:0]    request_bytes;
    logic                out_valid;
    logic                out_ready;
    logic                is_chunk;
    logic [PTR_W-1:0]    chunk_addr;
    logic [WORDS_W-1:0]  chunk_words;
    logic [OFFS_W-1:0]   available;
    logic [PTR_W-1:0]    own_value;
    logic [PTR_W-1:0]    unserved;
    logic                notify;
    logic                last;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CIDX_W-1:0]   cfg_index;
    logic [PTR_W-1:0]    cfg_data;

    ring_scoreboard sb = new();
    int sender_idle = 33;
    int receiver_idle = 66;
    int requests_sent = 0;
    int loads_sent = 0;
    int reg_writes = 0;
    int stall_cycles = 0;

    phase_bit_ring_pipe_engine dut (.*);

    initial clk = 1'b0;
    always #6 clk = ~clk;

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        cmd = pbr_pkg::CMD_LOAD;
        partner_value = '0;
        request_bytes = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = pbr_pkg::REG_BASE;
        cfg_data = '0;
    end

    always @(negedge clk)
        out_ready = ($urandom_range(99) >= receiver_idle);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(ring_result_t'{is_chunk, chunk_addr, chunk_words, available,
                                           own_value, unserved, notify, last});
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Timeout: no request or result moved for %0d cycles", STALL_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic update_pacing();
        if (requests_sent < 70)
        begin
            sender_idle = 33;
            receiver_idle = 66;
        end
        else if (requests_sent < 140)
        begin
            sender_idle = 66;
            receiver_idle = 33;
        end
        else
        begin
            sender_idle = 0;
            receiver_idle = 0;
        end
    endtask

    task automatic send_item(input logic c, input logic [PTR_W-1:0] pv,
                             input logic [PTR_W-1:0] rb);
        while ($urandom_range(99) < sender_idle)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        cmd = c;
        partner_value = pv;
        request_bytes = rb;
        in_valid = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_request(c, pv, rb);
        requests_sent++;
        if (c == pbr_pkg::CMD_LOAD)
            loads_sent++;
        update_pacing();
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid = 1'b0;
        while (sb.expected_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [PTR_W-1:0] data);
        cfg_index = idx;
        cfg_data = data;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(idx, data);
        reg_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Partner pointer that keeps the ring consistent: fill is the readable byte count.
    function automatic logic [PTR_W-1:0] consistent_partner(int fill);
        int l;
        int off;
        logic ph;
        l = sb.ring_size();
        off = int'(sb.own_ptr[OFFS_W-1:0]);
        ph = sb.own_ptr[PTR_W-1];
        if (off >= l)
            return PTR_W'($urandom);
        if (sb.dir_reg == pbr_pkg::DIR_READ)
        begin
            off = off + fill;
            if (off >= l)
            begin
                off = off - l;
                ph = ~ph;
            end
        end
        else
        begin
            off = off - fill;
            if (off < 0)
            begin
                off = off + l;
                ph = ~ph;
            end
        end
        return {ph, off[OFFS_W-1:0]};
    endfunction

    function automatic int pick_fill(int l);
        case ($urandom_range(7))
            0: return 0;
            1: return l;
            2: return $urandom_range(l - 1) | 1;
            default: return $urandom_range(l / 2) * 2;
        endcase
    endfunction

    function automatic logic [PTR_W-1:0] pick_request(int l);
        case ($urandom_range(9))
            0: return '0;
            1: return PTR_W'($urandom);
            2: return PTR_W'($urandom_range(3, 1));
            3, 4: return PTR_W'($urandom_range(l / 2, 1) * 2);
            5, 6: return PTR_W'($urandom_range(2 * l));
            7: return PTR_W'(l);
            8: return PTR_W'($urandom_range(20) | 1);
            default: return 16'hFFFF;
        endcase
    endfunction

    task automatic random_item();
        int r;
        int l;
        l = sb.ring_size();
        r = $urandom_range(99);
        if (r < 30)
            send_item(pbr_pkg::CMD_LOAD, consistent_partner(pick_fill(l)), PTR_W'($urandom));
        else if (r < 40)
            send_item(pbr_pkg::CMD_LOAD, PTR_W'($urandom), PTR_W'($urandom));
        else if (r < 92)
            send_item(pbr_pkg::CMD_XFER, PTR_W'($urandom), pick_request(l));
        else
            send_item(pbr_pkg::CMD_XFER, PTR_W'($urandom), PTR_W'($urandom));
    endtask

    task automatic apply_setting(int p);
        wait_drained();
        case (p)
            0:
            begin
                write_reg(pbr_pkg::REG_BASE, 16'h1234);
                write_reg(pbr_pkg::REG_RING, 16'd64);
                write_reg(pbr_pkg::REG_DIR, 16'(pbr_pkg::DIR_READ));
            end
            1:
            begin
                write_reg(pbr_pkg::REG_BASE, 16'hFFF0);
                write_reg(pbr_pkg::REG_DIR, 16'(pbr_pkg::DIR_WRITE));
            end
            2:
            begin
                write_reg(pbr_pkg::REG_BASE, 16'h0000);
                write_reg(pbr_pkg::REG_RING, 16'd6);
                write_reg(pbr_pkg::REG_DIR, 16'(pbr_pkg::DIR_READ));
            end
            3:
            begin
                write_reg(pbr_pkg::REG_BASE, PTR_W'($urandom));
                write_reg(pbr_pkg::REG_RING, 16'd1000);
                write_reg(pbr_pkg::REG_DIR, 16'(pbr_pkg::DIR_WRITE));
            end
            4:
            begin
                write_reg(pbr_pkg::REG_BASE, 16'h0100);
                write_reg(pbr_pkg::REG_RING, 16'd7);
                write_reg(pbr_pkg::REG_DIR, 16'(pbr_pkg::DIR_READ));
            end
            5:
            begin
                write_reg(pbr_pkg::REG_BASE, 16'h8000);
                write_reg(pbr_pkg::REG_RING, 16'd0);
                write_reg(pbr_pkg::REG_DIR, 16'(pbr_pkg::DIR_WRITE));
            end
            6:
            begin
                write_reg(pbr_pkg::REG_BASE, PTR_W'($urandom));
                write_reg(pbr_pkg::REG_RING, 16'd32766);
                write_reg(pbr_pkg::REG_DIR, 16'(pbr_pkg::DIR_READ));
            end
            default:
            begin
                write_reg(pbr_pkg::REG_BASE, 16'hFFFF);
                write_reg(pbr_pkg::REG_RING, 16'hFFFF);
                write_reg(pbr_pkg::REG_DIR, 16'hFFFF);
            end
        endcase
    endtask

    task automatic run_directed();
        send_item(pbr_pkg::CMD_XFER, PTR_W'($urandom), 16'd4);
        send_item(pbr_pkg::CMD_LOAD, 16'h8000, 16'h0000);
        send_item(pbr_pkg::CMD_XFER, 16'h0000, 16'hFFFF);
        send_item(pbr_pkg::CMD_XFER, 16'hFFFF, 16'h0000);
        send_item(pbr_pkg::CMD_LOAD, 16'hFFFF, 16'hFFFF);
        send_item(pbr_pkg::CMD_XFER, 16'h0000, 16'd6);
        wait_drained();
        write_reg(pbr_pkg::REG_BASE, 16'hFFFF);
        write_reg(pbr_pkg::REG_RING, 16'd16);
        write_reg(pbr_pkg::REG_DIR, 16'hFFFF);
        write_reg(REG_NONE, 16'h5555);
        send_item(pbr_pkg::CMD_LOAD, consistent_partner(0), 16'h0000);
        send_item(pbr_pkg::CMD_XFER, 16'h0000, 16'd40);
        send_item(pbr_pkg::CMD_XFER, 16'h0000, 16'd3);
        send_item(pbr_pkg::CMD_LOAD, consistent_partner(16), 16'h0000);
        send_item(pbr_pkg::CMD_XFER, 16'h0000, 16'd8);
        send_item(pbr_pkg::CMD_LOAD, consistent_partner(5), 16'h0000);
        send_item(pbr_pkg::CMD_XFER, 16'h0000, 16'd20);
        wait_drained();
        write_reg(pbr_pkg::REG_BASE, 16'h0000);
        write_reg(pbr_pkg::REG_RING, 16'd1);
        write_reg(pbr_pkg::REG_DIR, 16'h0000);
        send_item(pbr_pkg::CMD_LOAD, consistent_partner(2), 16'h0000);
        send_item(pbr_pkg::CMD_XFER, 16'h0000, 16'd2);
        send_item(pbr_pkg::CMD_XFER, 16'h0000, 16'd2);
        wait_drained();
        write_reg(pbr_pkg::REG_BASE, 16'h8001);
        write_reg(pbr_pkg::REG_RING, 16'hFFFF);
        send_item(pbr_pkg::CMD_LOAD, consistent_partner(32766), 16'h0000);
        send_item(pbr_pkg::CMD_XFER, 16'h0000, 16'hFFFE);
        send_item(pbr_pkg::CMD_XFER, 16'h0000, 16'hFFFF);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        run_directed();
        for (int p = 0; p < 8; p++)
        begin
            apply_setting(p);
            for (int i = 0; i < 24; i++)
            begin
                if (p == 3 && i == 12)
                    wait_drained();
                random_item();
            end
        end
        wait_drained();
        repeat (10) @(posedge clk);
        $display("Sent %0d requests (%0d pointer loads) over %0d register writes,",
                 requests_sent, loads_sent, reg_writes);
        $display("checked %0d results including %0d chunks, %0d mismatches.",
                 sb.results_seen, sb.chunks_seen, sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
